/* hdl/wl512_pkg.sv */
package wl512_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int WORD_W     = 32;
    localparam int LCG_OUT_W  = 15;

    localparam logic [WORD_W-1:0]    LCG_MUL     = 32'd214013;
    localparam logic [WORD_W-1:0]    LCG_ADD     = 32'd2531011;
    localparam logic [LCG_OUT_W-1:0] LCG_MASK    = 15'h7FFF;
    localparam logic [WORD_W-1:0]    TEMPER_MASK = 32'hDA442D24;

    // tap offsets relative to the current position, modulo the pool depth
    localparam logic [ADDR_W-1:0] OFS_C    = 4'd13;
    localparam logic [ADDR_W-1:0] OFS_D    = 4'd9;
    localparam logic [ADDR_W-1:0] OFS_TAIL = 4'd15;

    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    typedef struct packed {
        logic seed_load;  // load LCG state, clear fill counter
        logic seed_zero;  // use zero instead of the input seed
        logic lcg_write;  // advance LCG and write one pool word
        logic rd_second;  // select the second pair of read taps
        logic b_load;     // capture intermediate b from first read pair
        logic wr_new;     // write pool[p], capture tail word
        logic wr_tail;    // write pool[p-1], move position, load result
    } wl512_cmd_t;

    typedef struct packed {
        logic fill_last;
    } wl512_sts_t;

endpackage

/* hdl/wl512_datapath.sv */
module wl512_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wl512_pkg::wl512_cmd_t               cmd,
    output wl512_pkg::wl512_sts_t               sts,
    input  logic [wl512_pkg::WORD_W-1:0]        seed,
    output logic [wl512_pkg::WORD_W-1:0]        value
);
    import wl512_pkg::*;

    logic [WORD_W-1:0] pool_mem [POOL_DEPTH];

    logic [ADDR_W-1:0] position_reg;
    logic [ADDR_W-1:0] fill_cnt_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] x_next;
    logic [WORD_W-1:0] rd0_reg;
    logic [WORD_W-1:0] rd1_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] b_next;
    logic [WORD_W-1:0] tail_reg;
    logic [WORD_W-1:0] tail_next;
    logic [WORD_W-1:0] value_reg;

    logic [ADDR_W-1:0] rd_addr0;
    logic [ADDR_W-1:0] rd_addr1;
    logic [ADDR_W-1:0] tail_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [WORD_W-1:0] c_mix;
    logic [WORD_W-1:0] a_new;
    logic [WORD_W-1:0] d_mix;

    assign x_next = WORD_W'(x_reg * LCG_MUL) + LCG_ADD;

    assign tail_addr = position_reg + OFS_TAIL;
    assign rd_addr0  = cmd.rd_second ? position_reg + OFS_D : position_reg;
    assign rd_addr1  = cmd.rd_second ? tail_addr : position_reg + OFS_C;

    // first pair: rd0 = pool[p], rd1 = pool[p+13]
    assign b_next = rd0_reg ^ rd1_reg ^ (rd0_reg << 16) ^ (rd1_reg << 15);

    // second pair: rd0 = pool[p+9], rd1 = pool[p+15]
    assign c_mix     = rd0_reg ^ (rd0_reg >> 11);
    assign a_new     = b_reg ^ c_mix;
    assign d_mix     = a_new ^ ((a_new << 5) & TEMPER_MASK);
    assign tail_next = rd1_reg ^ b_reg ^ d_mix ^ (rd1_reg << 2) ^ (b_reg << 18) ^ (c_mix << 28);

    always_comb begin
        wr_en   = cmd.lcg_write | cmd.wr_new | cmd.wr_tail;
        wr_addr = position_reg;
        wr_data = a_new;
        if (cmd.lcg_write) begin
            wr_addr = fill_cnt_reg;
            wr_data = {{(WORD_W-LCG_OUT_W){1'b0}}, x_next[16 +: LCG_OUT_W] & LCG_MASK};
        end else if (cmd.wr_tail) begin
            wr_addr = tail_addr;
            wr_data = tail_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pool_mem[wr_addr] <= wr_data;
        end
        rd0_reg <= pool_mem[rd_addr0];
        rd1_reg <= pool_mem[rd_addr1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            fill_cnt_reg <= '0;
        end else begin
            if (cmd.seed_load) begin
                fill_cnt_reg <= '0;
            end else if (cmd.lcg_write) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == ADDR_W'(POOL_DEPTH - 1)) begin
                    position_reg <= '0;
                end
            end
            if (cmd.wr_tail) begin
                position_reg <= tail_addr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed_load) begin
            x_reg <= cmd.seed_zero ? '0 : seed;
        end else if (cmd.lcg_write) begin
            x_reg <= x_next;
        end
        if (cmd.b_load) begin
            b_reg <= b_next;
        end
        if (cmd.wr_new) begin
            tail_reg <= tail_next;
        end
        if (cmd.wr_tail) begin
            value_reg <= tail_reg;
        end
    end

    assign sts.fill_last = (fill_cnt_reg == ADDR_W'(POOL_DEPTH - 1));
    assign value         = value_reg;

endmodule

/* hdl/wl512_ctrl.sv */
module wl512_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_mode,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wl512_pkg::wl512_cmd_t cmd,
    input  wl512_pkg::wl512_sts_t sts
);
    import wl512_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_FILL,
        S_IDLE,
        S_RD2,
        S_WR1,
        S_WR2
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR: begin
                cmd.seed_load = 1'b1;
                cmd.seed_zero = 1'b1;
                state_next    = S_FILL;
            end
            S_FILL: begin
                cmd.lcg_write = 1'b1;
                if (sts.fill_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // read taps p and p+13 are issued every idle cycle
                if (accept) begin
                    if (in_mode == MODE_RESEED) begin
                        cmd.seed_load = 1'b1;
                        state_next    = S_FILL;
                    end else begin
                        state_next = S_RD2;
                    end
                end
            end
            S_RD2: begin
                cmd.rd_second = 1'b1;
                cmd.b_load    = 1'b1;
                state_next    = S_WR1;
            end
            S_WR1: begin
                cmd.wr_new = 1'b1;
                state_next = S_WR2;
            end
            S_WR2: begin
                if (out_free) begin
                    cmd.wr_tail    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_rose_after_wr2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_WR2))
        else $error("result valid without finished draw");

    a_wr2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR2 && out_valid_reg && !out_ready) |=> (state_reg == S_WR2))
        else $error("draw completed over a pending result");

    a_draw_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_mode == MODE_DRAW) |=> (state_reg == S_RD2))
        else $error("accepted draw did not start");

    a_fill_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL && !sts.fill_last) |=> (state_reg == S_FILL))
        else $error("pool fill ended early");

endmodule

/* hdl/well512_random_generator.sv */
// Draw: S_RD2, S_WR1, S_WR2 (held while a result is pending); no new item before S_IDLE.
// Reseed: pool fill runs one LCG multiply per cycle, busy until the pool is full, no result.
// Single write port on the 16-word pool (two writes per draw); throughput set by the FSM.
// Reset (aresetn low, synchronous) clears control and runs a zero-seed fill:
// s_tready stays low through S_CLEAR and S_FILL after reset is released.
module well512_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] seed
    input  logic [0:0]  s_tuser,  // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // [31:0] value
);
    import wl512_pkg::*;

    wl512_cmd_t cmd;
    wl512_sts_t sts;

    wl512_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    wl512_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .seed    (s_tdata),
        .value   (m_tdata)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import wl512_pkg::*;

    localparam int PHASE_ITEMS = 165;
    localparam int HOLD_LEN    = 300;
    localparam int WDOG_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 24;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = MODE_RESEED;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    well512_random_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // shadow copy of the generator state
    logic [WORD_W-1:0] rng_pool [POOL_DEPTH];
    logic [ADDR_W-1:0] rng_pos;
    logic [WORD_W-1:0] draws_due [$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int err_cnt   = 0;
    int chk_cnt   = 0;
    int sent_cnt  = 0;
    int reseed_cnt = 0;
    int quiet_cnt = 0;
    logic [WORD_W-1:0] want_val;

    typedef struct packed {
        logic        mode;
        logic [31:0] seed;
    } stim_t;

    // draws right after reset, ignored seeds, seed extremes, back-to-back reseeds
    stim_t dir_tab [24] = '{
        '{MODE_DRAW,   32'h0000_0000},
        '{MODE_DRAW,   32'hFFFF_FFFF},
        '{MODE_DRAW,   32'h1234_5678},
        '{MODE_RESEED, 32'hFFFF_FFFF},
        '{MODE_DRAW,   32'h0000_0000},
        '{MODE_RESEED, 32'h0000_0000},
        '{MODE_RESEED, 32'h0000_0001},
        '{MODE_DRAW,   32'hAAAA_AAAA},
        '{MODE_DRAW,   32'h5555_5555},
        '{MODE_RESEED, 32'h8000_0000},
        '{MODE_DRAW,   32'h0000_0000},
        '{MODE_DRAW,   32'hFFFF_FFFF},
        '{MODE_DRAW,   32'h0000_0001},
        '{MODE_DRAW,   32'h8000_0000},
        '{MODE_DRAW,   32'h7FFF_FFFF},
        '{MODE_DRAW,   32'hDEAD_BEEF},
        '{MODE_DRAW,   32'h0F0F_0F0F},
        '{MODE_DRAW,   32'hF0F0_F0F0},
        '{MODE_DRAW,   32'h0000_FFFF},
        '{MODE_DRAW,   32'hFFFF_0000},
        '{MODE_RESEED, 32'h7FFF_FFFF},
        '{MODE_DRAW,   32'h0000_0000},
        '{MODE_RESEED, 32'hDEAD_BEEF},
        '{MODE_DRAW,   32'hFFFF_FFFF}
    };

    function automatic void lcg_fill(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] x;
        x = seed;
        for (int k = 0; k < POOL_DEPTH; k++) begin
            x = x * LCG_MUL + LCG_ADD;
            rng_pool[ADDR_W'(k)] = (x >> 16) & WORD_W'(LCG_MASK);
        end
        rng_pos = '0;
    endfunction

    function automatic logic [WORD_W-1:0] well_step();
        logic [ADDR_W-1:0] p, idx;
        logic [WORD_W-1:0] a, b, c, d;
        p   = rng_pos;
        a   = rng_pool[p];
        idx = p + OFS_C;
        c   = rng_pool[idx];
        b   = a ^ c ^ (a << 16) ^ (c << 15);
        idx = p + OFS_D;
        c   = rng_pool[idx];
        c   = c ^ (c >> 11);
        a   = b ^ c;
        rng_pool[p] = a;
        d   = a ^ ((a << 5) & TEMPER_MASK);
        p   = p + OFS_TAIL;
        a   = rng_pool[p];
        rng_pool[p] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
        rng_pos = p;
        return rng_pool[p];
    endfunction

    // offer one transaction, hold it until accepted, then update the shadow state
    task automatic send_item(input logic mode, input logic [31:0] seed);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
        if (mode == MODE_RESEED) begin
            reseed_cnt++;
            lcg_fill(seed);
        end else begin
            draws_due.push_back(well_step());
        end
    endtask

    // sender pauses until every pending draw has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (draws_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (draws_due.size() == 0) begin
                $error("value: expected none, got %h", m_tdata);
                err_cnt++;
            end else begin
                want_val = draws_due.pop_front();
                chk_cnt++;
                if (m_tdata !== want_val) begin
                    $error("value: expected %h, got %h", want_val, m_tdata);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cnt);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin
        logic        mode;
        logic [31:0] seed;
        lcg_fill('0);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_item(dir_tab[i].mode, dir_tab[i].seed);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    gap_pct = 0;
                    stall_pct <= 0;
                    // long receiver hold-off while the sender keeps pushing
                    hold_reqs <= hold_reqs + 1;
                end
                1: begin
                    gap_pct = 86;
                    stall_pct <= 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct <= 86;
                end
                default: begin
                    gap_pct = 25;
                    stall_pct <= 25;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 8) begin
                    mode = MODE_RESEED;
                    case ($urandom_range(7))
                        0:       seed = '0;
                        1:       seed = '1;
                        default: seed = $urandom;
                    endcase
                end else begin
                    mode = MODE_DRAW;
                    seed = $urandom;
                end
                send_item(mode, seed);
            end
            settle();
        end

        $display("run covered %0d transactions in (%0d reseeds), %0d draws checked,",
                 sent_cnt, reseed_cnt, chk_cnt);
        $display("over free-running, sparse-sender, stalled-receiver and mixed traffic");
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
